/* hdl/qvr_pkg.sv */
// shared types, constants and arithmetic helpers for the quaternion vector rotator
package qvr_pkg;

  localparam int FieldWidth        = 32;
  localparam int FracBitsDefault   = 16;
  localparam int ValueWidthDefault = 32;
  localparam int CfgIdxWidth       = 3;
  localparam int NumEntries        = 9;
  localparam int NumProducts       = 10;
  localparam int QueueDepth        = 2;
  localparam int ProdWidth         = 64;
  localparam int AccWidth          = 66;

  localparam logic signed [FieldWidth-1:0] QuatWReset = 32'sd65536;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_QUAT_W = 3'd0,
    CFG_QUAT_X = 3'd1,
    CFG_QUAT_Y = 3'd2,
    CFG_QUAT_Z = 3'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    PROD_WW = 4'd0,
    PROD_XX = 4'd1,
    PROD_YY = 4'd2,
    PROD_ZZ = 4'd3,
    PROD_XY = 4'd4,
    PROD_XZ = 4'd5,
    PROD_YZ = 4'd6,
    PROD_WX = 4'd7,
    PROD_WY = 4'd8,
    PROD_WZ = 4'd9
  } prod_e;

  typedef enum logic [1:0] {
    SETUP_IDLE,
    SETUP_MUL,
    SETUP_SUM
  } setup_state_e;

  typedef logic signed [FieldWidth-1:0] field_t;

  typedef struct packed {
    field_t x;
    field_t y;
    field_t z;
    field_t w;
  } vec_t;

  typedef struct packed {
    logic busy;
    logic done;
  } setup_stat_t;

  typedef struct packed {
    logic hold;
  } front_ctrl_t;

  function automatic logic signed [AccWidth-1:0] sx_acc(input logic signed [ProdWidth-1:0] v);
    return {{(AccWidth-ProdWidth){v[ProdWidth-1]}}, v};
  endfunction

  function automatic logic signed [AccWidth-1:0] sat_acc(input logic signed [AccWidth-1:0] v,
                                                         input int eff);
    logic signed [AccWidth-1:0] hi;
    logic signed [AccWidth-1:0] lo;
    hi = (AccWidth'(1) << (eff - 1)) - AccWidth'(1);
    lo = ~hi;
    if (v > hi) begin
      return hi;
    end
    if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

endpackage

/* hdl/qvr_setup.sv */
// configuration registers and sequenced matrix builder with one shared multiplier
module qvr_setup import qvr_pkg::*; #(
  parameter int FRAC_BITS   = FracBitsDefault,
  parameter int VALUE_WIDTH = ValueWidthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CfgIdxWidth-1:0]        cfg_idx_i,
  input  logic [FieldWidth-1:0]         cfg_data_i,
  output setup_stat_t                   stat_o,
  output logic signed [((VALUE_WIDTH > FieldWidth) ? FieldWidth : VALUE_WIDTH)-1:0]
                                        mat_o [NumEntries]
);

  localparam int EffWidth = (VALUE_WIDTH > FieldWidth) ? FieldWidth : VALUE_WIDTH;
  localparam int CntWidth = $clog2(NumProducts);
  localparam logic signed [AccWidth-1:0] DiagSat = sat_acc(AccWidth'(1) << FRAC_BITS, EffWidth);

  setup_state_e state_q, state_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  field_t quat_w_q, quat_w_d, quat_x_q, quat_x_d, quat_y_q, quat_y_d, quat_z_q, quat_z_d;
  logic signed [ProdWidth-1:0] prod_q [NumProducts];
  logic signed [EffWidth-1:0] mat_q [NumEntries];
  logic signed [EffWidth-1:0] mat_d [NumEntries];
  logic signed [AccWidth-1:0] ent_sum [NumEntries];
  logic signed [AccWidth-1:0] ent_sat [NumEntries];
  logic signed [AccWidth-1:0] px [NumProducts];
  field_t op_a, op_b;
  logic   op_square;
  logic signed [ProdWidth-1:0] mul_full, mul_shift;
  logic cfg_hit, busy, mul_en, sum_en;

  assign cfg_hit = cfg_we_i &&
                   (cfg_idx_i inside {CFG_QUAT_W, CFG_QUAT_X, CFG_QUAT_Y, CFG_QUAT_Z});

  always_comb begin
    quat_w_d = quat_w_q;
    quat_x_d = quat_x_q;
    quat_y_d = quat_y_q;
    quat_z_d = quat_z_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_QUAT_W: quat_w_d = cfg_data_i;
        CFG_QUAT_X: quat_x_d = cfg_data_i;
        CFG_QUAT_Y: quat_y_d = cfg_data_i;
        CFG_QUAT_Z: quat_z_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    if (cfg_hit) begin
      state_d = SETUP_MUL;
    end else begin
      case (state_q)
        SETUP_IDLE: state_d = SETUP_IDLE;
        SETUP_MUL: begin
          if (cnt_q == PROD_WZ) state_d = SETUP_SUM;
        end
        SETUP_SUM: state_d = SETUP_IDLE;
        default:   state_d = SETUP_IDLE;
      endcase
    end
  end

  // outputs
  always_comb begin
    busy   = 1'b0;
    mul_en = 1'b0;
    sum_en = 1'b0;
    case (state_q)
      SETUP_IDLE: ;
      SETUP_MUL: begin
        busy   = 1'b1;
        mul_en = 1'b1;
      end
      SETUP_SUM: begin
        busy   = 1'b1;
        sum_en = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cfg_hit) begin
      cnt_d = '0;
    end else if (mul_en) begin
      cnt_d = cnt_q + CntWidth'(1);
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    op_a      = quat_w_q;
    op_b      = quat_w_q;
    op_square = 1'b1;
    case (cnt_q)
      PROD_WW: begin op_a = quat_w_q; op_b = quat_w_q; op_square = 1'b1; end
      PROD_XX: begin op_a = quat_x_q; op_b = quat_x_q; op_square = 1'b1; end
      PROD_YY: begin op_a = quat_y_q; op_b = quat_y_q; op_square = 1'b1; end
      PROD_ZZ: begin op_a = quat_z_q; op_b = quat_z_q; op_square = 1'b1; end
      PROD_XY: begin op_a = quat_x_q; op_b = quat_y_q; op_square = 1'b0; end
      PROD_XZ: begin op_a = quat_x_q; op_b = quat_z_q; op_square = 1'b0; end
      PROD_YZ: begin op_a = quat_y_q; op_b = quat_z_q; op_square = 1'b0; end
      PROD_WX: begin op_a = quat_w_q; op_b = quat_x_q; op_square = 1'b0; end
      PROD_WY: begin op_a = quat_w_q; op_b = quat_y_q; op_square = 1'b0; end
      PROD_WZ: begin op_a = quat_w_q; op_b = quat_z_q; op_square = 1'b0; end
      default: begin op_a = quat_w_q; op_b = quat_w_q; op_square = 1'b1; end
    endcase
  end

  // doubled cross terms shift one bit less
  assign mul_full  = ProdWidth'(op_a) * ProdWidth'(op_b);
  assign mul_shift = op_square ? (mul_full >>> FRAC_BITS) : (mul_full >>> (FRAC_BITS - 1));

  always_comb begin
    for (int i = 0; i < NumProducts; i++) begin
      px[i] = sx_acc(prod_q[i]);
    end
    ent_sum[0] = px[PROD_WW] + px[PROD_XX] - px[PROD_YY] - px[PROD_ZZ];
    ent_sum[1] = px[PROD_XY] - px[PROD_WZ];
    ent_sum[2] = px[PROD_XZ] + px[PROD_WY];
    ent_sum[3] = px[PROD_XY] + px[PROD_WZ];
    ent_sum[4] = px[PROD_WW] - px[PROD_XX] + px[PROD_YY] - px[PROD_ZZ];
    ent_sum[5] = px[PROD_YZ] - px[PROD_WX];
    ent_sum[6] = px[PROD_XZ] - px[PROD_WY];
    ent_sum[7] = px[PROD_YZ] + px[PROD_WX];
    ent_sum[8] = px[PROD_WW] - px[PROD_XX] - px[PROD_YY] + px[PROD_ZZ];
    for (int i = 0; i < NumEntries; i++) begin
      ent_sat[i] = sat_acc(ent_sum[i], EffWidth);
      mat_d[i]   = ent_sat[i][EffWidth-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SETUP_IDLE;
      cnt_q    <= '0;
      quat_w_q <= QuatWReset;
      quat_x_q <= '0;
      quat_y_q <= '0;
      quat_z_q <= '0;
      for (int i = 0; i < NumEntries; i++) begin
        mat_q[i] <= ((i % 4) == 0) ? DiagSat[EffWidth-1:0] : '0;
      end
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      quat_w_q <= quat_w_d;
      quat_x_q <= quat_x_d;
      quat_y_q <= quat_y_d;
      quat_z_q <= quat_z_d;
      if (sum_en) begin
        for (int i = 0; i < NumEntries; i++) begin
          mat_q[i] <= mat_d[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      prod_q[cnt_q] <= mul_shift;
    end
  end

  assign mat_o       = mat_q;
  assign stat_o.busy = busy;
  assign stat_o.done = sum_en;

endmodule

/* hdl/qvr_front.sv */
// input acceptance, w saturation and the item queue toward the back end
module qvr_front import qvr_pkg::*; #(
  parameter int VALUE_WIDTH = ValueWidthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  front_ctrl_t ctrl_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  field_t      vec_x_i,
  input  field_t      vec_y_i,
  input  field_t      vec_z_i,
  input  field_t      vec_w_i,
  output logic        item_valid_o,
  input  logic        item_ready_i,
  output vec_t        item_o
);

  localparam int EffWidth = (VALUE_WIDTH > FieldWidth) ? FieldWidth : VALUE_WIDTH;
  localparam int PtrWidth = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntWidth = $clog2(QueueDepth + 1);

  vec_t queue_q [QueueDepth];
  logic [PtrWidth-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic signed [AccWidth-1:0] w_sat;
  vec_t in_item;
  logic push, pop;

  assign w_sat     = sat_acc(AccWidth'(vec_w_i), EffWidth);
  assign in_item.x = vec_x_i;
  assign in_item.y = vec_y_i;
  assign in_item.z = vec_z_i;
  assign in_item.w = w_sat[FieldWidth-1:0];

  assign in_ready_o   = (cnt_q < CntWidth'(QueueDepth)) && !ctrl_i.hold;
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = queue_q[rd_ptr_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = item_valid_o && item_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrWidth'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrWidth'(1);
    end
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + CntWidth'(1);
      2'b01:   cnt_d = cnt_q - CntWidth'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= in_item;
    end
  end

endmodule

/* hdl/qvr_back.sv */
// two-stage matrix-vector datapath: products, then shifted sums with saturation
module qvr_back import qvr_pkg::*; #(
  parameter int FRAC_BITS   = FracBitsDefault,
  parameter int VALUE_WIDTH = ValueWidthDefault
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   item_valid_i,
  output logic   item_ready_o,
  input  vec_t   item_i,
  input  logic signed [((VALUE_WIDTH > FieldWidth) ? FieldWidth : VALUE_WIDTH)-1:0]
                 mat_i [NumEntries],
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output field_t out_x_o,
  output field_t out_y_o,
  output field_t out_z_o,
  output field_t out_w_o
);

  localparam int EffWidth = (VALUE_WIDTH > FieldWidth) ? FieldWidth : VALUE_WIDTH;

  field_t vin [3];
  field_t ent_ext [NumEntries];
  logic signed [ProdWidth-1:0] prod_d [NumEntries];
  logic signed [ProdWidth-1:0] prod_q [NumEntries];
  logic signed [AccWidth-1:0]  acc [3];
  logic signed [AccWidth-1:0]  acc_sat [3];
  field_t s1_w_q;
  logic s1_valid_q, out_valid_q;
  logic s1_adv, out_adv;
  field_t out_x_q, out_y_q, out_z_q, out_w_q;

  assign vin[0] = item_i.x;
  assign vin[1] = item_i.y;
  assign vin[2] = item_i.z;

  assign out_adv      = !out_valid_q || out_ready_i;
  assign s1_adv       = !s1_valid_q || out_adv;
  assign item_ready_o = s1_adv;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        ent_ext[r*3+c] = FieldWidth'(mat_i[r*3+c]);
        prod_d[r*3+c]  = ProdWidth'(ent_ext[r*3+c]) * ProdWidth'(vin[c]);
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = sx_acc(prod_q[r*3]   >>> FRAC_BITS)
             + sx_acc(prod_q[r*3+1] >>> FRAC_BITS)
             + sx_acc(prod_q[r*3+2] >>> FRAC_BITS);
      acc_sat[r] = sat_acc(acc[r], EffWidth);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv) s1_valid_q <= item_valid_i;
      if (out_adv) out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && item_valid_i) begin
      for (int i = 0; i < NumEntries; i++) begin
        prod_q[i] <= prod_d[i];
      end
      s1_w_q <= item_i.w;
    end
    if (out_adv && s1_valid_q) begin
      out_x_q <= acc_sat[0][FieldWidth-1:0];
      out_y_q <= acc_sat[1][FieldWidth-1:0];
      out_z_q <= acc_sat[2][FieldWidth-1:0];
      out_w_q <= s1_w_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign out_z_o     = out_z_q;
  assign out_w_o     = out_w_q;

endmodule

/* hdl/quaternion_vector_rotator.sv */
// quaternion vector rotator top level: setup, front queue and back datapath
// one item per cycle unless the output stalls or a write or rebuild holds the input;
// an item passes the queue, product registers and output register; the two-entry queue
// and output register let input and output stall independently; a quaternion register
// write rebuilds the matrix on one shared multiplier, during which no item is accepted
// reset is asynchronous active low: identity matrix, quat_w 65536, queue and pipeline empty
module quaternion_vector_rotator import qvr_pkg::*; #(
  parameter int FRAC_BITS   = FracBitsDefault,
  parameter int VALUE_WIDTH = ValueWidthDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [FieldWidth-1:0]  cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  field_t                 vec_x_i,
  input  field_t                 vec_y_i,
  input  field_t                 vec_z_i,
  input  field_t                 vec_w_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output field_t                 out_x_o,
  output field_t                 out_y_o,
  output field_t                 out_z_o,
  output field_t                 out_w_o
);

  localparam int EffWidth = (VALUE_WIDTH > FieldWidth) ? FieldWidth : VALUE_WIDTH;
  localparam logic signed [FieldWidth-1:0] SatHi = FieldWidth'((64'sd1 <<< (EffWidth - 1)) - 1);
  localparam logic signed [FieldWidth-1:0] SatLo = ~SatHi;

  setup_stat_t setup_stat;
  front_ctrl_t front_ctrl;
  logic signed [EffWidth-1:0] mat [NumEntries];
  logic item_valid, item_ready;
  vec_t item;

  assign front_ctrl.hold = setup_stat.busy || cfg_we_i;

  qvr_setup #(
    .FRAC_BITS  (FRAC_BITS),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_setup (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .stat_o    (setup_stat),
    .mat_o     (mat)
  );

  qvr_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (front_ctrl),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .vec_x_i     (vec_x_i),
    .vec_y_i     (vec_y_i),
    .vec_z_i     (vec_z_i),
    .vec_w_i     (vec_w_i),
    .item_valid_o(item_valid),
    .item_ready_i(item_ready),
    .item_o      (item)
  );

  qvr_back #(
    .FRAC_BITS  (FRAC_BITS),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(item_valid),
    .item_ready_o(item_ready),
    .item_i      (item),
    .mat_i       (mat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .out_z_o     (out_z_o),
    .out_w_o     (out_w_o)
  );

  // no item enters while the matrix is being rebuilt
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    setup_stat.busy |-> !in_ready_o)
    else $error("item accepted during matrix rebuild");

  // a quaternion write starts a rebuild
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && (cfg_idx_i == CFG_QUAT_W || cfg_idx_i == CFG_QUAT_X ||
                  cfg_idx_i == CFG_QUAT_Y || cfg_idx_i == CFG_QUAT_Z)) |=> setup_stat.busy)
    else $error("register write did not start a rebuild");

  // the final sum step ends the rebuild unless a new write restarts it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (setup_stat.done && !cfg_we_i) |=> !setup_stat.busy)
    else $error("rebuild did not finish after the sum step");

  // passed-through w is always within the saturation range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_w_o <= SatHi && out_w_o >= SatLo))
    else $error("out_w outside saturation range");

endmodule
